// ===== rtl/hashed_block_buffer_cache_top_macros.svh =====
// Assertion helpers for the buffer cache
`ifndef HASHED_BLOCK_BUFFER_CACHE_TOP_MACROS_SVH
`define HASHED_BLOCK_BUFFER_CACHE_TOP_MACROS_SVH
// implication checked every clock, masked during reset
`define HBC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define HBC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/hbc_pkg.sv =====
// ----------------------------------------------------------------------------
// hbc_pkg
// Types, constants and helpers shared by the buffer cache modules.
// ----------------------------------------------------------------------------
package hbc_pkg;
    localparam int NUM_BUFFERS_DEF = 32;
    localparam int NUM_BUCKETS_DEF = 13;
    localparam logic [7:0] REFS_MAX = 8'd255;

    localparam logic [1:0] MODE_GET     = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_PIN     = 2'd2;
    localparam logic [1:0] MODE_UNPIN   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOBUF = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_OVER  = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  device;
        logic [31:0] block_number;
        logic [4:0]  buffer_index;
    } t_in;

    typedef struct packed {
        logic [4:0] slot;
        logic       hit;
        logic       needs_read;
        logic [1:0] status;
    } t_out;

    // per-cell command, broadcast to every cell
    typedef struct packed {
        logic        clr_scan;  // start a new search pass
        logic        scan;      // token moves one rank down
        logic [5:0]  bucket;    // bucket the pass looks at
        logic        want_hit;  // pass matches tag, else free slot
        logic [7:0]  device;
        logic [31:0] block;
    } t_scan;
endpackage

// ===== rtl/hbc_cell.sv =====
// ----------------------------------------------------------------------------
// hbc_cell
// One buffer entry. Holds tag, count, flags, bucket and rank; joins the
// rank-ordered search by comparing its rank with the scan rank.
// ----------------------------------------------------------------------------
module hbc_cell #(
    parameter int NUM_BUFFERS = hbc_pkg::NUM_BUFFERS_DEF,
    parameter int NUM_BUCKETS = hbc_pkg::NUM_BUCKETS_DEF,
    parameter int IDX         = 0,
    localparam int RW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hbc_pkg::t_scan       i_scan,
    input  logic [RW-1:0]        i_scan_rank,
    // chain: match seen in a newer-ranked position is not needed since
    // at most one cell holds a rank; cell reports its own match
    output logic                 o_match,
    output logic [7:0]           o_refs,
    output logic                 o_loaded,
    output logic [31:0]          o_block,
    input  logic                 i_wr,        // update this entry
    input  logic [7:0]           i_refs,
    input  logic                 i_set_tag,
    input  logic                 i_set_loaded,
    input  logic                 i_set_bucket,
    input  logic [5:0]           i_bucket,
    input  logic                 i_newest,    // some cell becomes newest
    input  logic [RW-1:0]        i_newest_old // its old rank
);
    logic [7:0]    r_device;
    logic [31:0]   r_block;
    logic [7:0]    r_refs;
    logic          r_loaded;
    logic [5:0]    r_bucket;
    logic [RW-1:0] r_rank;

    assign o_match = (r_rank == i_scan_rank) && (r_bucket == i_scan.bucket) &&
        (i_scan.want_hit ? (r_device == i_scan.device && r_block == i_scan.block)
                         : (r_refs == 8'd0));
    assign o_refs   = r_refs;
    assign o_loaded = r_loaded;
    assign o_block  = r_block;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device <= '0;
            r_block  <= '0;
            r_refs   <= '0;
            r_loaded <= 1'b0;
            r_bucket <= 6'(IDX % NUM_BUCKETS);
            r_rank   <= RW'(IDX);
        end else begin
            if (i_wr) begin
                r_refs <= i_refs;
                if (i_set_tag) begin
                    r_device <= i_scan.device;
                    r_block  <= i_scan.block;
                end
                if (i_set_loaded) r_loaded <= 1'b1;
                if (i_set_bucket) r_bucket <= i_bucket;
            end
            if (i_newest) begin
                if (i_wr && i_set_bucket) r_rank <= RW'(NUM_BUFFERS - 1);
                else if (r_rank > i_newest_old) r_rank <= r_rank - 1'b1;
            end
        end
    end
endmodule

// ===== rtl/hashed_block_buffer_cache_top.sv =====
// ----------------------------------------------------------------------------
// hashed_block_buffer_cache_top
// Buffer cache: hashed buckets, recency ranks, free-buffer stealing.
// ----------------------------------------------------------------------------
// channel | dir | handshake         | payload
// in      | in  | i_valid / o_ready | i_data  (hbc_pkg::t_in)
// out     | out | o_valid / i_ready | o_data  (hbc_pkg::t_out)
// A get first reduces the block number modulo the bucket count, one nibble per
// cycle, then walks ranks newest to oldest, one rank per cycle, per pass: a
// tag pass over the home bucket, a free pass over it, then one free pass per
// other bucket, and then passes through S_OUT into the output register. A
// release also runs the reduction on the stored block, then S_GO and S_OUT;
// pin and unpin go through S_GO and S_OUT only.
// One transaction at a time; a stalled result holds in the output register
// and blocks the next input. Reset is synchronous.
module hashed_block_buffer_cache_top #(
    parameter int NUM_BUFFERS = hbc_pkg::NUM_BUFFERS_DEF,
    parameter int NUM_BUCKETS = hbc_pkg::NUM_BUCKETS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  hbc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output hbc_pkg::t_out o_data
);
`include "hashed_block_buffer_cache_top_macros.svh"
    localparam int RW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int SW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam logic [10:0] MB1 = 11'(NUM_BUCKETS);
    localparam logic [10:0] MB2 = 11'(NUM_BUCKETS * 2);
    localparam logic [10:0] MB4 = 11'(NUM_BUCKETS * 4);
    localparam logic [10:0] MB8 = 11'(NUM_BUCKETS * 8);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_MOD  = 6'b000010, S_SCAN = 6'b000100,
        S_GO   = 6'b001000, S_OTH  = 6'b010000, S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    hbc_pkg::t_in r_req;
    logic [5:0]    r_rem;   // block modulo buckets, built a nibble per cycle
    logic [5:0]    r_cnt;
    logic [RW-1:0] r_rank;
    logic [5:0]    r_bkt;
    logic          r_hitpass;
    logic [5:0]    r_npass; // free passes finished, the home free pass included
    logic          r_ovalid;
    hbc_pkg::t_out r_odata;

    hbc_pkg::t_scan scan;
    logic [NUM_BUFFERS-1:0] match;
    logic [7:0]  refs_a  [NUM_BUFFERS];
    logic        load_a  [NUM_BUFFERS];
    logic [31:0] blk_a   [NUM_BUFFERS];

    logic [NUM_BUFFERS-1:0] wr;
    logic [7:0]  wr_refs;
    logic        set_tag, set_loaded, set_bucket, newest;
    logic [5:0]  wr_bucket;
    logic [RW-1:0] newest_old;
    logic [SW-1:0] act;
    logic        any_match;
    logic [SW-1:0] msel;
    logic [RW-1:0] rank_sel [NUM_BUFFERS];

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

    always_comb begin
        scan.clr_scan = 1'b0;
        scan.scan     = (r_state == S_SCAN);
        scan.bucket   = r_bkt;
        scan.want_hit = r_hitpass;
        scan.device   = r_req.device;
        scan.block    = r_req.block_number;
    end

    for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_cell
        hbc_cell #(.NUM_BUFFERS(NUM_BUFFERS), .NUM_BUCKETS(NUM_BUCKETS), .IDX(g)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_scan(scan), .i_scan_rank(r_rank),
            .o_match(match[g]), .o_refs(refs_a[g]), .o_loaded(load_a[g]),
            .o_block(blk_a[g]), .i_wr(wr[g]), .i_refs(wr_refs), .i_set_tag(set_tag),
            .i_set_loaded(set_loaded), .i_set_bucket(set_bucket), .i_bucket(wr_bucket),
            .i_newest(newest), .i_newest_old(newest_old));
        assign rank_sel[g] = '0;
    end

    always_comb begin
        any_match = |match;
        msel = '0;
        for (int i = 0; i < NUM_BUFFERS; i++)
            if (match[i]) msel = SW'(i);
    end

    // remainder step: rem*16 + nibble stays below 16*NUM_BUCKETS, so four
    // conditional subtracts bring it back under NUM_BUCKETS
    logic [31:0] mod_src;
    logic [3:0]  mod_nib;
    logic [10:0] mod_val;
    logic [5:0]  rem2;
    always_comb begin
        mod_src = (r_req.mode == hbc_pkg::MODE_GET) ? r_req.block_number :
                  blk_a[r_req.buffer_index[SW-1:0]];
        mod_nib = 4'(mod_src >> {3'd7 - r_cnt[2:0], 2'b00});
        mod_val = {1'b0, r_rem, mod_nib};
        if (mod_val >= MB8) mod_val = mod_val - MB8;
        if (mod_val >= MB4) mod_val = mod_val - MB4;
        if (mod_val >= MB2) mod_val = mod_val - MB2;
        if (mod_val >= MB1) mod_val = mod_val - MB1;
        rem2 = mod_val[5:0];
    end

    logic [RW-1:0] r_actrank;
    logic [5:0]    nb;
    always_comb begin
        nb = (r_bkt == 6'(NUM_BUCKETS - 1)) ? '0 : r_bkt + 6'd1;
    end

    always_comb begin
        n_state = r_state;
        wr = '0; wr_refs = '0; set_tag = 1'b0; set_loaded = 1'b0;
        set_bucket = 1'b0; wr_bucket = r_rem; newest = 1'b0; newest_old = r_actrank;
        act = r_req.buffer_index[SW-1:0];
        case (r_state)
            S_IDLE: if (i_valid && o_ready)
                n_state = (i_data.mode == hbc_pkg::MODE_GET ||
                           i_data.mode == hbc_pkg::MODE_RELEASE) ? S_MOD : S_GO;
            S_MOD:  if (r_cnt == 6'd7)
                n_state = (r_req.mode == hbc_pkg::MODE_GET) ? S_SCAN : S_GO;
            S_SCAN: if (any_match || (r_rank == '0 && !r_hitpass &&
                                      r_npass == 6'(NUM_BUCKETS - 1)))
                n_state = S_OUT;
            S_GO:   n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
        // get completion
        if (r_state == S_SCAN && any_match) begin
            act = msel;
            if (r_hitpass) begin
                if (refs_a[msel] != hbc_pkg::REFS_MAX) begin
                    wr[msel] = 1'b1; wr_refs = refs_a[msel] + 8'd1; set_loaded = 1'b1;
                end
            end else begin
                wr[msel] = 1'b1; wr_refs = 8'd1; set_tag = 1'b1; set_loaded = 1'b1;
                if (r_npass != '0) begin
                    set_bucket = 1'b1; newest = 1'b1; newest_old = r_rank;
                end
            end
        end
        // release / pin / unpin
        if (r_state == S_GO && (int'(r_req.buffer_index) < NUM_BUFFERS)) begin
            if (r_req.mode == hbc_pkg::MODE_PIN) begin
                if (refs_a[act] != hbc_pkg::REFS_MAX) begin
                    wr[act] = 1'b1; wr_refs = refs_a[act] + 8'd1;
                end
            end else if (refs_a[act] != 8'd0) begin
                wr[act] = 1'b1; wr_refs = refs_a[act] - 8'd1;
                if (r_req.mode == hbc_pkg::MODE_RELEASE && refs_a[act] == 8'd1) begin
                    set_bucket = 1'b1; wr_bucket = r_rem;
                    newest = 1'b1; newest_old = r_actrank;
                end
            end
        end
    end

    // rank of a released buffer: the cell ranks are not exported, so a dedicated
    // rank mirror is kept and read when the request is taken.
    logic [RW-1:0] r_rank_m [NUM_BUFFERS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_BUFFERS; i++) r_rank_m[i] <= RW'(i);
        end else if (newest) begin
            for (int i = 0; i < NUM_BUFFERS; i++) begin
                if (wr[i] && set_bucket) r_rank_m[i] <= RW'(NUM_BUFFERS - 1);
                else if (r_rank_m[i] > newest_old) r_rank_m[i] <= r_rank_m[i] - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ovalid <= 1'b0; r_cnt <= '0; r_rank <= '0;
            r_bkt <= '0; r_hitpass <= 1'b0; r_npass <= '0; r_rem <= '0;
            r_actrank <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_req <= i_data; r_cnt <= '0; r_rem <= '0;
                    r_actrank <= r_rank_m[i_data.buffer_index[SW-1:0]];
                    r_odata <= '{slot: i_data.buffer_index, hit: 1'b0,
                                 needs_read: 1'b0, status: hbc_pkg::ST_OK};
                end
                S_MOD: begin
                    r_rem <= rem2; r_cnt <= r_cnt + 6'd1;
                    r_bkt <= rem2; r_rank <= RW'(NUM_BUFFERS - 1);
                    r_hitpass <= 1'b1; r_npass <= '0;
                end
                S_SCAN: begin
                    if (any_match) begin
                        r_odata.slot <= 5'(msel);
                        r_odata.hit  <= r_hitpass;
                        if (r_hitpass && refs_a[msel] == hbc_pkg::REFS_MAX)
                            r_odata.status <= hbc_pkg::ST_OVER;
                        else
                            r_odata.needs_read <= r_hitpass ? !load_a[msel] : 1'b1;
                    end else if (r_rank == '0) begin
                        r_rank <= RW'(NUM_BUFFERS - 1);
                        if (r_hitpass) r_hitpass <= 1'b0;
                        else begin
                            r_npass <= r_npass + 6'd1;
                            r_bkt <= nb;
                        end
                        if (!r_hitpass && r_npass == 6'(NUM_BUCKETS - 1)) begin
                            r_odata.slot <= '0; r_odata.status <= hbc_pkg::ST_NOBUF;
                        end
                    end else r_rank <= r_rank - 1'b1;
                end
                S_GO: if (int'(r_req.buffer_index) < NUM_BUFFERS) begin
                    if (r_req.mode == hbc_pkg::MODE_PIN) begin
                        if (refs_a[act] == hbc_pkg::REFS_MAX)
                            r_odata.status <= hbc_pkg::ST_OVER;
                    end else if (refs_a[act] == 8'd0) r_odata.status <= hbc_pkg::ST_UNDER;
                end
                S_OUT: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end

    logic unused_ok;
    assign unused_ok = ^{scan.clr_scan, scan.scan, rank_sel[0], r_rank_m[0] == '0};

    `HBC_ASSERT_IMP(a_onehot_match, i_clk, i_rst_n, 1'b1, $onehot0(match))
    `HBC_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, !o_ready)
    `HBC_ASSERT_NXT(a_out_after, i_clk, i_rst_n, r_state == S_OUT, o_valid)
endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Checks the hashed buffer cache against a behavioral copy kept here: gets,
// releases, pins and unpins with random idling, a long output stall, and
// a pause until the cache has answered every transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    localparam int NBUF = 32;
    localparam int NBKT = 13;
    localparam int WATCHDOG_LIMIT = 20000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    hbc_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_ready;
    hbc_pkg::t_out o_data;

    int    mismatch_count = 0;
    bit    stall_done = 0;

    task automatic report_mismatch(string what, int want, int got);
        $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard: behavioral cache state and pending answers.
    // ------------------------------------------------------------------------
    class cache_scoreboard;
        logic [7:0]    dev_tbl   [NBUF];
        logic [31:0]   blk_tbl   [NBUF];
        logic [7:0]    refs_tbl  [NBUF];
        bit            loaded_tbl[NBUF];
        int            bucket_tbl[NBUF];
        int            rank_tbl  [NBUF];
        hbc_pkg::t_out pending_q [$];

        function new();
            for (int i = 0; i < NBUF; i++) begin
                dev_tbl[i] = '0;
                blk_tbl[i] = '0;
                refs_tbl[i] = '0;
                loaded_tbl[i] = 0;
                bucket_tbl[i] = i % NBKT;
                rank_tbl[i] = i;
            end
        endfunction

        function void promote(int s);
            int old;
            old = rank_tbl[s];
            for (int i = 0; i < NBUF; i++)
                if (rank_tbl[i] > old) rank_tbl[i]--;
            rank_tbl[s] = NBUF - 1;
        endfunction

        // newest free buffer of bucket b, or -1
        function int newest_free(int b);
            for (int r = NBUF - 1; r >= 0; r--)
                for (int s = 0; s < NBUF; s++)
                    if (rank_tbl[s] == r && bucket_tbl[s] == b && refs_tbl[s] == 0)
                        return s;
            return -1;
        endfunction

        function void note_request(hbc_pkg::t_in req);
            hbc_pkg::t_out res;
            int   home;
            int   found;
            int   idx;
            res = '0;
            res.slot = req.buffer_index;
            res.status = hbc_pkg::ST_OK;
            idx = int'(req.buffer_index);
            if (req.mode == hbc_pkg::MODE_GET) begin
                home = int'(req.block_number % NBKT);
                found = -1;
                for (int r = NBUF - 1; r >= 0 && found < 0; r--)
                    for (int s = 0; s < NBUF; s++)
                        if (rank_tbl[s] == r && bucket_tbl[s] == home &&
                            dev_tbl[s] == req.device && blk_tbl[s] == req.block_number)
                            found = s;
                if (found >= 0) begin
                    res.slot = 5'(found);
                    res.hit = 1'b1;
                    if (refs_tbl[found] == hbc_pkg::REFS_MAX) begin
                        res.status = hbc_pkg::ST_OVER;
                    end else begin
                        refs_tbl[found]++;
                        res.needs_read = !loaded_tbl[found];
                        loaded_tbl[found] = 1;
                    end
                end else begin
                    found = newest_free(home);
                    for (int k = 1; k < NBKT && found < 0; k++) begin
                        found = newest_free((home + k) % NBKT);
                        if (found >= 0) begin
                            bucket_tbl[found] = home;
                            promote(found);
                        end
                    end
                    if (found < 0) begin
                        res.slot = '0;
                        res.status = hbc_pkg::ST_NOBUF;
                    end else begin
                        res.slot = 5'(found);
                        dev_tbl[found] = req.device;
                        blk_tbl[found] = req.block_number;
                        refs_tbl[found] = 8'd1;
                        loaded_tbl[found] = 1;
                        res.needs_read = 1'b1;
                    end
                end
            end else if (req.mode == hbc_pkg::MODE_PIN) begin
                if (refs_tbl[idx] == hbc_pkg::REFS_MAX) res.status = hbc_pkg::ST_OVER;
                else refs_tbl[idx]++;
            end else if (refs_tbl[idx] == 0) begin
                res.status = hbc_pkg::ST_UNDER;
            end else begin
                refs_tbl[idx]--;
                if (req.mode == hbc_pkg::MODE_RELEASE && refs_tbl[idx] == 0) begin
                    bucket_tbl[idx] = int'(blk_tbl[idx] % NBKT);
                    promote(idx);
                end
            end
            pending_q.push_back(res);
        endfunction

        task check_answer(hbc_pkg::t_out got);
            hbc_pkg::t_out want;
            if (pending_q.size() == 0) begin
                report_mismatch("answer with none pending", 0, got.slot);
                return;
            end
            want = pending_q.pop_front();
            if (got.slot != want.slot)
                report_mismatch("slot", want.slot, got.slot);
            if (got.hit != want.hit)
                report_mismatch("hit", want.hit, got.hit);
            if (got.needs_read != want.needs_read)
                report_mismatch("needs_read", want.needs_read, got.needs_read);
            if (got.status != want.status)
                report_mismatch("status", want.status, got.status);
        endtask
    endclass

    cache_scoreboard sb;

    hashed_block_buffer_cache_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    // valid stays high from one transaction into the next when there is no gap
    task automatic send_request(logic [1:0] mode, logic [7:0] dev, logic [31:0] blk,
                                logic [4:0] idx);
        hbc_pkg::t_in req;
        int  gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.mode = mode;
        req.device = dev;
        req.block_number = blk;
        req.buffer_index = idx;
        i_data <= req;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(req);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    // mostly small block numbers and few devices so that hits recur
    task automatic random_request();
        int          pick;
        logic [1:0]  mode;
        logic [31:0] blk;
        pick = $urandom_range(0, 99);
        mode = pick < 45 ? hbc_pkg::MODE_GET : pick < 75 ? hbc_pkg::MODE_RELEASE :
               pick < 88 ? hbc_pkg::MODE_PIN : hbc_pkg::MODE_UNPIN;
        blk = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
        send_request(mode, ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2)),
                     blk, 5'($urandom));
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fresh cache hit, extremes, every mode, underflow
        send_request(hbc_pkg::MODE_GET, 8'd0, 32'd0, 5'd0);
        send_request(hbc_pkg::MODE_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        send_request(hbc_pkg::MODE_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
        send_request(hbc_pkg::MODE_RELEASE, 8'h00, 32'h0, 5'd31);
        send_request(hbc_pkg::MODE_UNPIN, 8'hAA, 32'h5555_5555, 5'd7);
        send_request(hbc_pkg::MODE_PIN, 8'h55, 32'hAAAA_AAAA, 5'd7);
        send_request(hbc_pkg::MODE_UNPIN, 8'h0, 32'h0, 5'd7);
        send_request(hbc_pkg::MODE_RELEASE, 8'h0, 32'h0, 5'd7);
        // exhaust the pool: steal from other buckets, then no free buffer
        for (int i = 0; i < 34; i++)
            send_request(hbc_pkg::MODE_GET, 8'd3, 32'd1000 + i, 5'($urandom));
        for (int i = 0; i < NBUF; i++)
            send_request(hbc_pkg::MODE_RELEASE, 8'd0, 32'd0, 5'(i));
        // drive one count to its ceiling: pin and get overflow
        send_request(hbc_pkg::MODE_GET, 8'd9, 32'd77, 5'd0);
        for (int i = 0; i < 255; i++)
            send_request(hbc_pkg::MODE_PIN, 8'd0, 32'd0, sb.pending_q.size() == 0 ?
                         5'(0) : 5'(0));
        wait_drained();
        begin
            int s;
            s = -1;
            for (int i = 0; i < NBUF; i++)
                if (sb.dev_tbl[i] == 8'd9 && sb.blk_tbl[i] == 32'd77) s = i;
            send_request(hbc_pkg::MODE_PIN, 8'd0, 32'd0, 5'(s));
            send_request(hbc_pkg::MODE_GET, 8'd9, 32'd77, 5'd0);
            for (int i = 0; i < 256; i++)
                send_request(hbc_pkg::MODE_UNPIN, 8'd0, 32'd0, 5'(s));
        end

        for (int n = 0; n < 650; n++) begin
            if (n == 300) wait_drained();
            random_request();
        end
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && sb.pending_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        int seen;
        i_ready = 1'b0;
        seen = 0;
        @(posedge i_rst_n);
        forever begin
            if (!stall_done && seen >= 100) begin
                i_ready <= 1'b0;
                repeat (600) @(posedge i_clk);
                stall_done = 1;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 4);
            if (gap != 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            if (o_valid) begin
                sb.check_answer(o_data);
                seen++;
            end
        end
    end

    // watchdog: cycles with no transaction on either side
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle = 0;
            else idle++;
            if (idle >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end
endmodule
